@@ rtl/bsm_pkg.sv @@
// shared types, constants and the booth step function of the booth signed multiplier
// no dependencies
package bsm_pkg;

  localparam int OPERAND_BITS    = 8;
  localparam int ACC_BITS        = OPERAND_BITS + 1;
  localparam int PROD_BITS       = 2 * OPERAND_BITS;
  localparam int STEPS_PER_STAGE = 2;
  localparam int NUM_STAGES      = (OPERAND_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int IN_TDATA_BITS   = ((2 * OPERAND_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS  = ((PROD_BITS + 7) / 8) * 8;

  // working word carried through the pipeline
  typedef struct packed {
    logic [ACC_BITS-1:0]     m;
    logic [ACC_BITS-1:0]     acc;
    logic [OPERAND_BITS-1:0] q;
    logic                    prev;
  } stage_t;

  // one radix-2 recoding step followed by the joint arithmetic shift
  function automatic stage_t booth_step(stage_t s);
    stage_t r;
    logic [ACC_BITS-1:0] acc_n;
    acc_n = s.acc;
    if (s.q[0] && !s.prev) begin
      acc_n = s.acc - s.m;
    end else if (!s.q[0] && s.prev) begin
      acc_n = s.acc + s.m;
    end
    r.m    = s.m;
    r.prev = s.q[0];
    r.q    = {acc_n[0], s.q[OPERAND_BITS-1:1]};
    r.acc  = {acc_n[ACC_BITS-1], acc_n[ACC_BITS-1:1]};
    return r;
  endfunction

endpackage

@@ rtl/bsm_stage.sv @@
// one pipeline stage of the booth signed multiplier: STEPS_PER_STAGE booth steps and a register
// depends on bsm_pkg
module bsm_stage (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  bsm_pkg::stage_t                        in_data_i,
  input  logic [bsm_pkg::STEPS_PER_STAGE-1:0]    step_en_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output bsm_pkg::stage_t                        out_data_o
);

  logic            valid_q;
  bsm_pkg::stage_t data_q;
  bsm_pkg::stage_t data_d;

  always_comb begin
    data_d = in_data_i;
    for (int k = 0; k < bsm_pkg::STEPS_PER_STAGE; k++) begin
      if (step_en_i[k]) begin
        data_d = bsm_pkg::booth_step(data_d);
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/booth_signed_multiplier.sv @@
// top level of the booth signed multiplier: operand unpacking, stage chain, product packing
// depends on bsm_pkg and bsm_stage
//
// usage
//   slave channel s_axis_*: one item per handshake carries both factors
//   master channel m_axis_*: one item per input item carries the signed product
//   the eight booth steps are split over a chain of registered stages, two steps
//   per stage, so the default build has four stages
//   an accepted item passes through every stage register in order before m_axis_tvalid
//   throughput: one item per cycle while the receiver does not stall, set by the stage
//   chain where each stage holds one item
//   each stage takes a new item when it is empty or its successor takes its own,
//   so bubbles close up while the receiver stalls; s_axis_tready drops only
//   when every stage holds an item and m_axis_tready is low
//   the last stage register is the output register; a stalled product holds
//   reset: all stage valid bits clear, no item is in flight, the block is ready
//   at once; nothing is kept between items
module booth_signed_multiplier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // fields from bit 0: multiplicand (8, signed), multiplier (8, signed)
  input  logic [bsm_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // fields from bit 0: product (16, signed)
  output logic [bsm_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

  logic [bsm_pkg::OPERAND_BITS-1:0] multiplicand;
  logic [bsm_pkg::OPERAND_BITS-1:0] multiplier;
  logic [bsm_pkg::PROD_BITS-1:0]    product;

  // stage handshake and data chain, index 0 is the input side
  logic            valid_s [bsm_pkg::NUM_STAGES+1];
  logic            ready_s [bsm_pkg::NUM_STAGES+1];
  bsm_pkg::stage_t data_s  [bsm_pkg::NUM_STAGES+1];

  assign multiplicand = s_axis_tdata[bsm_pkg::OPERAND_BITS-1:0];
  assign multiplier   = s_axis_tdata[2*bsm_pkg::OPERAND_BITS-1:bsm_pkg::OPERAND_BITS];

  // initial working word: sign-extended multiplicand, clear accumulator and extra bit
  always_comb begin
    data_s[0].m    = {multiplicand[bsm_pkg::OPERAND_BITS-1], multiplicand};
    data_s[0].acc  = '0;
    data_s[0].q    = multiplier;
    data_s[0].prev = 1'b0;
  end

  assign valid_s[0]    = s_axis_tvalid;
  assign s_axis_tready = ready_s[0];

  for (genvar s = 0; s < bsm_pkg::NUM_STAGES; s++) begin : g_stage
    logic [bsm_pkg::STEPS_PER_STAGE-1:0] step_en;

    // the last stage may carry fewer steps when the operand width is odd
    for (genvar k = 0; k < bsm_pkg::STEPS_PER_STAGE; k++) begin : g_en
      assign step_en[k] = ((s * bsm_pkg::STEPS_PER_STAGE + k) < bsm_pkg::OPERAND_BITS);
    end

    bsm_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_s[s]),
      .in_ready_o  (ready_s[s]),
      .in_data_i   (data_s[s]),
      .step_en_i   (step_en),
      .out_valid_o (valid_s[s+1]),
      .out_ready_i (ready_s[s+1]),
      .out_data_o  (data_s[s+1])
    );
  end

  assign ready_s[bsm_pkg::NUM_STAGES] = m_axis_tready;
  assign m_axis_tvalid                = valid_s[bsm_pkg::NUM_STAGES];

  // product is the low accumulator bits above the shifted-out multiplier bits
  assign product = {data_s[bsm_pkg::NUM_STAGES].acc[bsm_pkg::OPERAND_BITS-1:0],
                    data_s[bsm_pkg::NUM_STAGES].q};

  always_comb begin
    m_axis_tdata                            = '0;
    m_axis_tdata[bsm_pkg::PROD_BITS-1:0]    = product;
  end

  // back pressure reaches the input only with a full chain and a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the stage chain could move");

  // an accepted item is held by the first stage in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_s[1])
    else $error("accepted item lost at the first stage");

  // the most negative product is above -2^(2n-2), so negative products keep the next bit set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && product[bsm_pkg::PROD_BITS-1]) |-> product[bsm_pkg::PROD_BITS-2])
    else $error("product outside the signed range of the factors");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the booth signed multiplier: streams factor pairs in,
// predicts every product with a local radix-2 booth recoder and checks the results
// depends on bsm_pkg and booth_signed_multiplier
module testbench;

  localparam int OPERAND_BITS   = bsm_pkg::OPERAND_BITS;
  localparam int PROD_BITS      = bsm_pkg::PROD_BITS;
  localparam int NUM_STAGES     = bsm_pkg::NUM_STAGES;
  localparam int IN_TDATA_BITS  = bsm_pkg::IN_TDATA_BITS;
  localparam int OUT_TDATA_BITS = bsm_pkg::OUT_TDATA_BITS;

  // recoding of the pair {low multiplier bit, previous bit}
  localparam logic [1:0] RECODE_SUB = 2'b10;
  localparam logic [1:0] RECODE_ADD = 2'b01;

  // cycles with no handshake on either side before the run is given up
  localparam int WATCHDOG_LIMIT = 2000;
  // longest receiver stall and longest sender gap, in cycles
  localparam int MAX_STALL = 12;
  localparam int MAX_GAP   = 6;
  localparam int RANDOM_ITEMS = 680;

  typedef logic signed [OPERAND_BITS-1:0] factor_t;
  typedef logic        [PROD_BITS-1:0]    product_t;

  // one product still owed by the block, with the factors kept for reporting
  typedef struct {
    factor_t  mcand;
    factor_t  mplier;
    product_t product;
  } owed_product_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  // every input has a known value from time zero
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // fields from bit 0: multiplicand (8, signed), multiplier (8, signed)
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // fields from bit 0: product (16, signed)
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

  owed_product_t owed_products[$];
  int            error_count    = 0;
  int            items_sent     = 0;
  int            products_seen  = 0;
  int            idle_cycles    = 0;

  // sender burst state and pacing knobs, set by the test tasks
  int            burst_left     = 0;
  int            gap_max        = 0;
  rx_mode_t      rx_mode        = RX_FREE;
  int            stall_left     = 0;

  booth_signed_multiplier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // radix-2 booth recoding over a one-bit-wider accumulator, one step per
  // multiplier bit, then a joint arithmetic shift of accumulator, multiplier
  // and the previous bit
  function automatic product_t booth_product_of(factor_t mcand, factor_t mplier);
    logic [OPERAND_BITS:0]   m;
    logic [OPERAND_BITS:0]   acc;
    logic [OPERAND_BITS-1:0] q;
    logic                    prev;
    m    = {mcand[OPERAND_BITS-1], mcand};
    acc  = '0;
    q    = mplier;
    prev = 1'b0;
    for (int k = 0; k < OPERAND_BITS; k++) begin
      case ({q[0], prev})
        RECODE_SUB: acc = acc - m;
        RECODE_ADD: acc = acc + m;
        default: ;
      endcase
      prev = q[0];
      q    = {acc[0], q[OPERAND_BITS-1:1]};
      acc  = {acc[OPERAND_BITS], acc[OPERAND_BITS:1]};
    end
    return {acc[OPERAND_BITS-1:0], q};
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // sends one factor pair; bursts of random length, with random idle gaps between
  // them set by gap_max; valid stays high from one item to the next in a burst
  task automatic send_pair(factor_t mcand, factor_t mplier);
    owed_product_t owed;
    int            gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_BITS'({mplier, mcand});
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    owed.mcand   = mcand;
    owed.mplier  = mplier;
    owed.product = booth_product_of(mcand, mplier);
    owed_products.push_back(owed);
    items_sent++;
    burst_left--;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_until_drained();
    while (owed_products.size() != 0) @(posedge clk_i);
  endtask

  // receiver: stalls of random length, started more or less often by mode
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if ((rx_mode == RX_LIGHT && $urandom_range(0, 7) == 0) ||
                 (rx_mode == RX_HEAVY && $urandom_range(0, 1) == 0)) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, MAX_STALL - 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // product checker: every accepted item against the oldest owed product
  always @(posedge clk_i) begin
    owed_product_t owed;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      products_seen++;
      if (owed_products.size() == 0) begin
        report_mismatch($sformatf("unexpected product 0x%h", m_axis_tdata));
      end else begin
        owed = owed_products.pop_front();
        if (m_axis_tdata[PROD_BITS-1:0] !== owed.product) begin
          report_mismatch($sformatf("%0d * %0d gave 0x%h, want 0x%h",
                                    owed.mcand, owed.mplier,
                                    m_axis_tdata[PROD_BITS-1:0], owed.product));
        end
        // fill bits above the product, if the byte padding leaves any
        if ((m_axis_tdata >> PROD_BITS) !== '0) begin
          report_mismatch("non-zero fill bits above the product");
        end
      end
    end
  end

  // watchdog: ends the run after too long with no handshake anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // every pairing of the field extremes and the small values, including
  // the most negative multiplicand times the most negative multiplier
  task automatic test_corner_factors();
    factor_t corners[5];
    corners = '{-128, 127, 0, 1, -1};
    rx_mode = RX_FREE;
    gap_max = 0;
    foreach (corners[i]) begin
      foreach (corners[j]) begin
        send_pair(corners[i], corners[j]);
      end
    end
  endtask

  // the sender holds off until every owed product has come back, then resumes
  task automatic test_pause_until_drained();
    rx_mode = RX_HEAVY;
    gap_max = 2;
    repeat (12) send_pair(factor_t'($urandom), factor_t'($urandom));
    stop_sending();
    wait_until_drained();
    repeat (8) send_pair(factor_t'($urandom), factor_t'($urandom));
  endtask

  // multipliers with runs of ones and zeros exercise long add/subtract chains
  function automatic factor_t run_pattern();
    int lo;
    int hi;
    lo = $urandom_range(0, OPERAND_BITS - 1);
    hi = $urandom_range(lo, OPERAND_BITS - 1);
    run_pattern = '0;
    for (int b = lo; b <= hi; b++) run_pattern[b] = 1'b1;
    if ($urandom_range(0, 1)) run_pattern = ~run_pattern;
  endfunction

  function automatic factor_t pick_factor();
    case ($urandom_range(0, 9))
      0:       pick_factor = $urandom_range(0, 1) ? factor_t'(-128) : factor_t'(127);
      1:       pick_factor = factor_t'($urandom_range(0, 2)) - factor_t'(1);
      2, 3:    pick_factor = run_pattern();
      default: pick_factor = factor_t'($urandom);
    endcase
  endfunction

  // random pairs in rounds, each round with its own sender and receiver pacing
  task automatic test_random_products();
    int round_len;
    int left;
    left = RANDOM_ITEMS;
    while (left > 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      gap_max   = $urandom_range(0, 3) == 0 ? 0 : MAX_GAP;
      round_len = $urandom_range(20, 80);
      if (round_len > left) round_len = left;
      repeat (round_len) send_pair(pick_factor(), pick_factor());
      left -= round_len;
    end
  endtask

  initial begin
    // reset held low from time zero, released on a rising edge
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_factors();
    test_pause_until_drained();
    test_random_products();

    stop_sending();
    rx_mode = RX_FREE;
    wait_until_drained();
    repeat (2 * NUM_STAGES) @(posedge clk_i);

    $display("sent %0d factor pairs (all corner pairings, a drain pause, random runs)",
             items_sent);
    $display("checked %0d products under varied sender gaps and receiver stalls",
             products_seen);
    if (error_count == 0 && owed_products.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d products never arrived",
               error_count, owed_products.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
